// ----- sv/sscf_pkg.sv -----
// Shared types, constants and trigonometry tables for the sector scan converter.
package sscf_pkg;

  localparam int unsigned AngleMax = 180;

  localparam logic [0:0] CfgOriginX = 1'b0;
  localparam logic [0:0] CfgOriginY = 1'b1;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] angle;
    logic [7:0] depth;
    logic [7:0] intensity;
    logic       ray_last;
  } in_word_t;

  typedef struct packed {
    logic [10:0]        pixel_x;
    logic signed [11:0] pixel_y;
    logic [7:0]         gray;
    logic               filled;
    logic               gap_skipped;
    logic               last;
  } out_word_t;

  // One classified job handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] angle;
    logic [7:0] depth;
    logic [7:0] prev_gray;
    logic [7:0] cur_gray;
    logic [7:0] first_angle;
    logic [6:0] gap;
    logic       do_fill;
    logic       skipped;
  } job_t;

  function automatic logic [15:0] quarter_sine(input logic [6:0] d);
    logic [15:0] v;
    case (d)
      7'd0: v = 16'd0;      7'd1: v = 16'd572;    7'd2: v = 16'd1144;
      7'd3: v = 16'd1715;   7'd4: v = 16'd2286;   7'd5: v = 16'd2856;
      7'd6: v = 16'd3425;   7'd7: v = 16'd3993;   7'd8: v = 16'd4560;
      7'd9: v = 16'd5126;   7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
      7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
      7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
      7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
      7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
      7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
      7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
      7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
      7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
      7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
      7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
      7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
      7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
      7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
      7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
      7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
      7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
      7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
      7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
      7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
      7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
      7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
      7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
      7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
      7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] sine_rom(input logic [7:0] a);
    logic [7:0] d;
    d = (a <= 8'd90) ? a : 8'(AngleMax) - a;
    return quarter_sine(d[6:0]);
  endfunction

  function automatic logic signed [16:0] cosine_rom(input logic [7:0] a);
    logic [7:0] d;
    if (a <= 8'd90) begin
      d = 8'd90 - a;
      return signed'({1'b0, quarter_sine(d[6:0])});
    end else begin
      d = a - 8'd90;
      return -signed'({1'b0, quarter_sine(d[6:0])});
    end
  endfunction

endpackage

// ----- sv/sector_scan_convert_fill.sv -----
// Sector scan converter with gap filling: top level and configuration registers.
// An in-range sample without fill passes the ray memory read, the job queue and the back end's
// multiply and place states on its way to its pixel word. The front end takes no new sample
// until the last one's ray memory read is done and its job is issued. Each fill pixel passes
// the serial gap divider in the back end. Reset clears the previous ray flag and angle and
// sets origin to (240, 280); the ray memory is not cleared.
module sector_scan_convert_fill import sscf_pkg::*; #(
  parameter int unsigned DEPTH   = 256,
  parameter int unsigned MAX_GAP = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  logic [9:0] origin_x_q, origin_y_q;
  logic  fj_valid, fj_ready, bj_valid, bj_ready;
  job_t  fj, bj;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= 10'd240;
      origin_y_q <= 10'd280;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOriginX: origin_x_q <= cfg_data_i;
        CfgOriginY: origin_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sscf_front #(.DEPTH(DEPTH), .MAX_GAP(MAX_GAP)) u_front (
    .clk_i, .rst_ni, .push, .full, .in_word_i,
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  sscf_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_job_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_job_o(bj)
  );

  sscf_back u_back (
    .clk_i, .rst_ni, .origin_x_i(origin_x_q), .origin_y_i(origin_y_q),
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .empty, .pop, .out_word_o
  );

endmodule

// ----- sv/sscf_front.sv -----
// Front end: ray memory, gap classification and job issue.
module sscf_front import sscf_pkg::*; #(
  parameter int unsigned DEPTH   = 256,
  parameter int unsigned MAX_GAP = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StIssue = 2'd2;

  logic [7:0] ray_mem [DEPTH];
  logic [7:0] mem_rd_q;

  logic [1:0] state_q, state_d;
  in_word_t   item_q;
  logic [7:0] sat_q;
  logic       in_range_q;
  logic [7:0] prev_angle_q;
  logic       prev_valid_q;

  logic [7:0] sat_a;
  logic       accept;
  logic       pv_eff;
  logic [8:0] gap_w;
  logic [AW-1:0] addr;

  assign accept = push && !full;
  assign full   = (state_q != StIdle);
  assign sat_a  = (in_word_i.angle > 8'(AngleMax)) ? 8'(AngleMax) : in_word_i.angle;
  assign addr   = AW'(item_q.depth);

  always_ff @(posedge clk_i) begin
    if (state_q == StRead) begin
      mem_rd_q <= ray_mem[addr];
    end
    if (state_q == StIssue && job_ready_i && in_range_q) begin
      ray_mem[addr] <= item_q.intensity;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_word_i;
      sat_q      <= sat_a;
      in_range_q <= (32'(in_word_i.depth) < DEPTH);
    end
  end

  // A frame start forgets the previous ray before this sample is judged.
  assign pv_eff = prev_valid_q && !item_q.frame_start;
  assign gap_w  = {1'b0, sat_q} - {1'b0, prev_angle_q};

  always_comb begin
    job_o.angle       = sat_q;
    job_o.depth       = item_q.depth;
    job_o.prev_gray   = mem_rd_q;
    job_o.cur_gray    = item_q.intensity;
    job_o.first_angle = prev_angle_q + 8'd1;
    job_o.gap         = gap_w[6:0];
    job_o.do_fill     = 1'b0;
    job_o.skipped     = 1'b0;
    if (pv_eff && sat_q > prev_angle_q + 8'd1) begin
      if (gap_w <= 9'(MAX_GAP)) begin
        job_o.do_fill = 1'b1;
      end else begin
        job_o.skipped = 1'b1;
      end
    end
  end

  assign job_valid_o = (state_q == StIssue) && in_range_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StRead;
      StRead:  state_d = StIssue;
      StIssue: if (job_ready_i || !in_range_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      prev_angle_q <= '0;
      prev_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIssue && (job_ready_i || !in_range_q)) begin
        if (item_q.frame_start) begin
          prev_valid_q <= 1'b0;
        end
        if (item_q.ray_last) begin
          prev_angle_q <= sat_q;
          prev_valid_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/sscf_queue.sv -----
// Two-entry job queue between the front and back ends.
module sscf_queue import sscf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_job_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_job_o
);

  job_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_job_o   = slot_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) slot_q[wp_q] <= wr_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ----- sv/sscf_back.sv -----
// Back end: fill interpolation with a serial divider, pixel placement, result register.
module sscf_back import sscf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [9:0] origin_x_i,
  input  logic [9:0] origin_y_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StPlace = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0] state_q, state_d;
  job_t       job_q;
  logic [6:0] k_q;
  logic       own_q;
  logic [14:0] num_q;
  logic [7:0]  quo_q;
  logic [7:0]  rem_q;
  logic [3:0]  bit_q;
  logic [7:0]  gray_q;
  logic [23:0] sprod_q;
  logic signed [25:0] cprod_q;
  out_word_t   res_q;
  logic        res_full_q;

  logic [14:0] num_w;
  logic [8:0]  trial;
  logic [7:0]  rem_sh;
  logic [7:0]  cur_ang;
  logic signed [25:0] neg_floor;
  logic [10:0] px;
  logic signed [11:0] py;

  assign job_ready_o = (state_q == StIdle);
  assign empty = !res_full_q;
  assign out_word_o = res_q;

  // Numerator of the interpolation for fill index k.
  assign num_w = 15'((job_q.gap - k_q) * job_q.prev_gray) + 15'(k_q * job_q.cur_gray);

  // One quotient bit per cycle, restoring division of a 15-bit value by the gap.
  assign rem_sh = {rem_q[6:0], num_q[14]};
  assign trial  = {1'b0, rem_sh} - {2'b0, job_q.gap};

  assign cur_ang = own_q ? job_q.angle : job_q.first_angle + 8'(k_q) - 8'd1;

  always_comb begin
    neg_floor = (cprod_q >= 0) ? (cprod_q >>> 15) : -((-cprod_q + 26'sd32767) >>> 15);
    px = 11'(origin_x_i) + 11'(sprod_q[23:15]);
    py = signed'({2'b0, origin_y_i}) - 12'(neg_floor);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (job_valid_i) state_d = job_i.do_fill ? StDiv : StMul;
      StDiv:   if (bit_q == 4'd0) state_d = StMul;
      StMul:   state_d = StPlace;
      StPlace: state_d = StOut;
      StOut: begin
        if (!res_full_q || pop) begin
          state_d = (own_q) ? StIdle : ((k_q + 7'd1 == job_q.gap) ? StMul : StDiv);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          job_q <= job_i;
          k_q   <= 7'd1;
          own_q <= !job_i.do_fill;
          num_q <= 15'(((job_i.gap - 7'd1) * job_i.prev_gray)) + 15'(job_i.cur_gray);
          rem_q <= '0;
          bit_q <= 4'd14;
        end
      end
      StDiv: begin
        num_q <= {num_q[13:0], 1'b0};
        if (!trial[8]) begin
          rem_q <= trial[7:0];
          quo_q <= {quo_q[6:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[6:0], 1'b0};
        end
        bit_q <= bit_q - 4'd1;
      end
      StMul: begin
        gray_q  <= own_q ? job_q.cur_gray : quo_q;
        sprod_q <= job_q.depth * sine_rom(cur_ang);
        cprod_q <= signed'({1'b0, job_q.depth}) * cosine_rom(cur_ang);
      end
      StOut: begin
        if ((!res_full_q || pop) && !own_q) begin
          if (k_q + 7'd1 == job_q.gap) begin
            own_q <= 1'b1;
          end else begin
            k_q   <= k_q + 7'd1;
            rem_q <= '0;
            bit_q <= 4'd14;
          end
        end
      end
      default: ;
    endcase
    if (state_q == StOut && (!res_full_q || pop) && !own_q && k_q + 7'd1 != job_q.gap) begin
      num_q <= num_w + 15'(job_q.cur_gray) - 15'(job_q.prev_gray);
    end
    if (state_q == StPlace) begin
      res_q.pixel_x     <= px;
      res_q.pixel_y     <= py;
      res_q.gray        <= gray_q;
      res_q.filled      <= !own_q;
      res_q.gap_skipped <= own_q && job_q.skipped;
      res_q.last        <= own_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      res_full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StPlace) begin
        res_full_q <= 1'b1;
      end else if (pop && res_full_q) begin
        res_full_q <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/sector_scan_convert_fill_tb.sv -----
// Self-checking testbench for the sector scan converter with gap filling.
module sector_scan_convert_fill_tb;
  import sscf_pkg::*;

  localparam int unsigned RayDepth = 256;
  localparam int unsigned GapLimit = 16;

  // Q1.15 sine for 0..90 degrees, rounded.
  localparam int unsigned QuarterWave[0:90] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768};

  class pixel_scoreboard;
    out_word_t  pending[$];
    logic [7:0] ray_gray[RayDepth];
    bit         ray_known[RayDepth];
    int         ray_angle;
    bit         ray_open;
    int         org_x;
    int         org_y;
    int         errors;
    int         pixels;
    int         fills;
    int         skips;

    function new();
      ray_angle = 0;
      ray_open  = 0;
      org_x     = 240;
      org_y     = 280;
    endfunction

    function int sin_q15(int a);
      return (a <= 90) ? QuarterWave[a] : QuarterWave[180 - a];
    endfunction

    function int cos_q15(int a);
      return (a <= 90) ? QuarterWave[90 - a] : -QuarterWave[a - 90];
    endfunction

    function out_word_t place(int a, int r, int g, bit fl, bit sk, bit lst);
      out_word_t w;
      int pc;
      int xs;
      int ys;
      pc = r * cos_q15(a);
      xs = org_x + ((r * sin_q15(a)) >>> 15);
      ys = org_y - (pc >>> 15);
      w.pixel_x     = xs[10:0];
      w.pixel_y     = ys[11:0];
      w.gray        = g[7:0];
      w.filled      = fl;
      w.gap_skipped = sk;
      w.last        = lst;
      return w;
    endfunction

    // Keeps a sample from interpolating against a depth never written.
    function in_word_t make_safe(in_word_t w);
      int a;
      int pick[$];
      a = (w.angle > AngleMax) ? AngleMax : w.angle;
      if (!w.frame_start && ray_open && a > ray_angle + 1 &&
          a - ray_angle <= GapLimit && !ray_known[w.depth]) begin
        for (int i = 0; i < RayDepth; i++)
          if (ray_known[i]) pick.push_back(i);
        if (pick.size() > 0) w.depth = 8'(pick[$urandom_range(0, pick.size() - 1)]);
        else w.frame_start = 1'b1;
      end
      return w;
    endfunction

    function void note_sample(in_word_t w);
      int a;
      int r;
      int cur;
      int gap;
      bit sk;
      a   = (w.angle > AngleMax) ? AngleMax : w.angle;
      r   = w.depth;
      cur = w.intensity;
      sk  = 0;
      if (w.frame_start) ray_open = 0;
      if (ray_open && a > ray_angle + 1) begin
        gap = a - ray_angle;
        if (gap <= GapLimit) begin
          for (int k = 1; k < gap; k++) begin
            pending.push_back(place(ray_angle + k, r,
                ((gap - k) * ray_gray[r] + k * cur) / gap, 1, 0, 0));
            fills++;
          end
        end else begin
          sk = 1;
          skips++;
        end
      end
      pending.push_back(place(a, r, cur, 0, sk, 1));
      ray_gray[r]  = cur[7:0];
      ray_known[r] = 1;
      if (w.ray_last) begin
        ray_angle = a;
        ray_open  = 1;
      end
    endfunction

    function void check_pixel(out_word_t got);
      out_word_t want;
      pixels++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel word %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.gray !== want.gray || got.filled !== want.filled ||
          got.gap_skipped !== want.gap_skipped || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("pixel %0d: expected %p, got %p", pixels, want, got);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  in_word_t   in_word_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_word_t  out_word_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = CfgOriginX;
  logic [9:0] cfg_data_i = '0;

  pixel_scoreboard sb = new();
  bit eager;
  int samples;
  int next_angle;

  sector_scan_convert_fill dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int idle_len();
    if (eager || $urandom_range(0, 1) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Called at a falling edge; returns at a falling edge with push still high.
  task automatic send_sample(in_word_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    w = sb.make_safe(w);
    push = 1'b1;
    in_word_i = w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_sample(w);
    samples++;
    @(negedge clk_i);
  endtask

  task automatic send_fields(bit fs, int a, int d, int g, bit rl);
    in_word_t w;
    w.frame_start = fs;
    w.angle       = a[7:0];
    w.depth       = d[7:0];
    w.intensity   = g[7:0];
    w.ray_last    = rl;
    send_sample(w);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    // A fill run may still be finishing inside the block.
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val[9:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgOriginX) sb.org_x = val[9:0];
    else sb.org_y = val[9:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly rays with rising angles and a shared depth pool, some noise.
  task automatic random_phase(int count);
    in_word_t w;
    int left;
    int step;
    bit fs;
    fs = 1;
    while (count > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        w = in_word_t'($bits(in_word_t)'($urandom()));
        send_sample(w);
        count--;
        continue;
      end
      step = $urandom_range(0, 19);
      if (step < 14) next_angle += $urandom_range(1, 3);
      else if (step < 17) next_angle += $urandom_range(4, 16);
      else if (step < 19) next_angle += $urandom_range(17, 40);
      else next_angle = $urandom_range(0, 255);
      if (next_angle > 200) begin
        next_angle = $urandom_range(0, 20);
        fs = 1;
      end
      left = $urandom_range(1, 4);
      while (left > 0 && count > 0) begin
        w.frame_start = fs;
        w.angle       = next_angle[7:0];
        w.depth       = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 7) * 36);
        w.intensity   = 8'($urandom_range(0, 255));
        w.ray_last    = (left == 1);
        send_sample(w);
        fs = 0;
        left--;
        count--;
      end
    end
  endtask

  // Receiver: random pops, with one long hold-off to back the block up.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else if (eager) pop = 1'b1;
      else pop = ($urandom_range(0, 3) != 0) || ($urandom_range(0, 30) == 0 ? 0 : 1);
      if (!eager && hold == 0 && $urandom_range(0, 60) == 0) hold = $urandom_range(5, 30);
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_pixel(out_word_o);
        if (!held && sb.pixels == 60) begin
          held = 1;
          hold = 300;
        end
      end
    end
  end

  initial begin
    int ox;
    int oy;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    eager = 0;
    @(negedge clk_i);

    // Directed: extremes, saturation, widest gap filled and just past it.
    send_fields(1, 0,   0,   0,   0);
    send_fields(0, 0,   255, 255, 1);
    send_fields(0, 2,   255, 0,   0);
    send_fields(0, 2,   0,   255, 0);
    send_fields(0, 2,   0,   100, 1);  // same depth twice in one ray
    send_fields(0, 18,  255, 200, 1);  // widest gap that still fills
    send_fields(0, 35,  0,   7,   1);  // one degree too wide
    send_fields(0, 200, 0,   9,   0);  // saturates to 180
    send_fields(0, 255, 255, 1,   1);
    send_fields(0, 90,  128, 77,  1);  // going backward
    send_fields(0, 91,  128, 66,  1);  // one degree forward
    send_fields(1, 120, 128, 55,  1);  // frame start drops the old ray
    send_fields(0, 130, 128, 250, 1);
    send_fields(0, 90,  1,   128, 1);
    send_fields(0, 180, 170, 85,  1);
    wait_drained();

    next_angle = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin ox = 0;    oy = 0;    end
        1: begin ox = 1023; oy = 1023; end
        default: begin
          ox = $urandom_range(0, 1023);
          oy = $urandom_range(0, 1023);
        end
      endcase
      write_reg(CfgOriginX, ox);
      write_reg(CfgOriginY, oy);
      eager = (ph == 2);
      random_phase(50);
      wait_drained();
    end

    $display("Sent %0d samples; checked %0d pixels (%0d fills, %0d skipped gaps).",
             samples, sb.pixels, sb.fills, sb.skips);
    $display("Origins covered both extremes and random values.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d pixels never arrived", sb.errors, sb.pending.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(20 * 800000);
    $display("Timed out with %0d pixels outstanding", sb.pending.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
